// File: hw/rtl/two_level_fingerprint_lce_core_defines.svh
// Assertion macros shared by the longest-common-extension core.
// No dependencies; the using module must provide clk and rst_n.
`ifndef TWO_LEVEL_FINGERPRINT_LCE_CORE_DEFINES_SVH
`define TWO_LEVEL_FINGERPRINT_LCE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TLFP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TLFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tlfp_pkg.sv
// Package for the longest-common-extension core: sizes, codes and shared types.
// No dependencies; used by every module of the core except tlfp_ram.
`default_nettype none

package tlfp_pkg;

    // Store depth and symbol size.
    localparam int MAX_LEN     = 4096;
    localparam int SYMBOL_BITS = 8;

    // Derived widths.
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int WALK_W  = LEN_W + 1;
    localparam int RANK_W  = ADDR_W;
    localparam int PRINT_W = 2 * RANK_W;
    localparam int CFG_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] CFG_STRING_LENGTH = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SHORT_STEP    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_LONG_STEP     = 2'd2;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD_SYMBOL = 2'd0;
    localparam logic [1:0] OP_LOAD_SUFFIX = 2'd1;
    localparam logic [1:0] OP_QUERY       = 2'd2;

    // Query engine control states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ_Q,
        ST_COMPARE,
        ST_FINISH
    } walk_state_t;

    // Which comparison the walk is doing.
    typedef enum logic [2:0] {
        PH_FIRST_SYMBOL,
        PH_FIRST_COARSE,
        PH_FINE,
        PH_COARSE,
        PH_SYMBOL
    } walk_phase_t;

    // Query start command with the effective configuration.
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] i;
        logic [LEN_W-1:0] j;
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] t1;
        logic [LEN_W-1:0] t2;
    } qry_cmd_t;

    // Write request into the fingerprint memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [RANK_W-1:0] coarse;
        logic [RANK_W-1:0] fine;
    } print_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/tlfp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module tlfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/tlfp_print_builder.sv
// Builds fingerprint table writes from suffix entries given in rank order.
// Depends on tlfp_pkg.
`default_nettype none

module tlfp_print_builder
    import tlfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [LEN_W-1:0]  position,
    input  wire logic [RANK_W-1:0] rank,
    input  wire logic [LEN_W-1:0]  lcp,
    input  wire logic [LEN_W-1:0]  t1,
    input  wire logic [LEN_W-1:0]  t2,
    output      print_wr_t         wr
);

    logic [RANK_W-1:0] short_print_reg;
    logic [RANK_W-1:0] short_print_next;
    logic [RANK_W-1:0] long_print_reg;
    logic [RANK_W-1:0] long_print_next;

    // A new run starts when the LCP falls below the step.
    always_comb
    begin
        short_print_next = short_print_reg;
        long_print_next  = long_print_reg;
        if (load && (lcp < t1))
        begin
            short_print_next = rank;
        end
        if (load && (lcp < t2))
        begin
            long_print_next = rank;
        end
        wr.we     = load && (position < LEN_W'(MAX_LEN));
        wr.addr   = position[ADDR_W-1:0];
        wr.coarse = short_print_next;
        wr.fine   = long_print_next;
    end

    // Current run heads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_print_reg <= '0;
            long_print_reg  <= '0;
        end
        else
        begin
            short_print_reg <= short_print_next;
            long_print_reg  <= long_print_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tlfp_query_engine.sv
// Query sequencer: walks the text and fingerprint memories for one query and
// holds the result item in an output register. Depends on tlfp_pkg and the
// assertion macro header.
`default_nettype none
`include "two_level_fingerprint_lce_core_defines.svh"

module tlfp_query_engine
    import tlfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire qry_cmd_t               cmd,
    output      logic                   busy,
    output      logic [ADDR_W-1:0]      rd_addr,
    input  wire logic [SYMBOL_BITS-1:0] text_rdata,
    input  wire logic [PRINT_W-1:0]     print_rdata,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic [LEN_W-1:0]       extension_length,
    output      logic                   out_of_range
);

    walk_state_t            state_reg, state_next;
    walk_phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]       i_reg, i_next;
    logic [LEN_W-1:0]       j_reg, j_next;
    logic [LEN_W-1:0]       n_reg, n_next;
    logic [LEN_W-1:0]       t1_reg, t1_next;
    logic [LEN_W-1:0]       t2_reg, t2_next;
    logic [WALK_W-1:0]      p_reg, p_next;
    logic [WALK_W-1:0]      q_reg, q_next;
    logic                   oor_reg, oor_next;
    logic [SYMBOL_BITS-1:0] hold_text_reg, hold_text_next;
    logic [PRINT_W-1:0]     hold_print_reg, hold_print_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]       out_len_reg, out_len_next;
    logic                   out_oor_reg, out_oor_next;

    logic                   in_bounds;
    logic                   data_match;
    logic                   chk_done;
    logic                   chk_ok;
    logic [WALK_W-1:0]      step;
    logic [WALK_W-1:0]      walked;
    logic [LEN_W-1:0]       far_pos;
    logic [LEN_W-1:0]       limit;
    logic [LEN_W-1:0]       capped_len;

    // Positions at or past the text end never match.
    assign in_bounds = (p_reg < WALK_W'(n_reg)) && (q_reg < WALK_W'(n_reg));

    // Compare the held entry of p with the entry of q now on the read port.
    always_comb
    begin
        case (phase_reg)
            PH_FIRST_SYMBOL, PH_SYMBOL:
            begin
                data_match = (hold_text_reg == text_rdata);
            end
            PH_FIRST_COARSE, PH_COARSE:
            begin
                data_match = (hold_print_reg[PRINT_W-1 -: RANK_W]
                              == print_rdata[PRINT_W-1 -: RANK_W]);
            end
            PH_FINE:
            begin
                data_match = (hold_print_reg[RANK_W-1:0] == print_rdata[RANK_W-1:0]);
            end
            default:
            begin
                data_match = 1'b0;
            end
        endcase
    end

    // Step size of the current phase.
    always_comb
    begin
        case (phase_reg)
            PH_FIRST_COARSE, PH_COARSE:
            begin
                step = WALK_W'(t1_reg);
            end
            PH_FINE:
            begin
                step = WALK_W'(t2_reg);
            end
            default:
            begin
                step = WALK_W'(1);
            end
        endcase
    end

    // Final length, capped at n minus the larger position.
    always_comb
    begin
        walked   = p_reg - WALK_W'(i_reg);
        far_pos  = (i_reg > j_reg) ? i_reg : j_reg;
        limit    = n_reg - far_pos;
        if (walked > WALK_W'(limit))
        begin
            capped_len = limit;
        end
        else
        begin
            capped_len = walked[LEN_W-1:0];
        end
    end

    // Next state and outputs of the walk.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        oor_next        = oor_reg;
        hold_text_next  = hold_text_reg;
        hold_print_next = hold_print_reg;
        out_len_next    = out_len_reg;
        out_oor_next    = out_oor_reg;
        out_valid_next  = out_valid_reg && out_stall;
        rd_addr         = q_reg[ADDR_W-1:0];
        chk_done        = 1'b0;
        chk_ok          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    i_next   = cmd.i;
                    j_next   = cmd.j;
                    n_next   = cmd.n;
                    t1_next  = cmd.t1;
                    t2_next  = cmd.t2;
                    p_next   = WALK_W'(cmd.i);
                    q_next   = WALK_W'(cmd.j);
                    oor_next = 1'b0;
                    if ((cmd.i > cmd.n) || (cmd.j > cmd.n))
                    begin
                        oor_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (cmd.i == cmd.j)
                    begin
                        // Equal positions extend to the end of the text.
                        p_next     = WALK_W'(cmd.n);
                        q_next     = WALK_W'(cmd.n);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        phase_next = PH_FIRST_SYMBOL;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                rd_addr = p_reg[ADDR_W-1:0];
                if (in_bounds)
                begin
                    state_next = ST_READ_Q;
                end
                else
                begin
                    chk_done = 1'b1;
                end
            end
            ST_READ_Q:
            begin
                hold_text_next  = text_rdata;
                hold_print_next = print_rdata;
                state_next      = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                chk_done = 1'b1;
                chk_ok   = data_match;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_oor_next   = oor_reg;
                    out_len_next   = oor_reg ? '0 : capped_len;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Phase transitions at the end of each comparison.
        if (chk_done)
        begin
            state_next = ST_CHECK;
            if (chk_ok)
            begin
                p_next = p_reg + step;
                q_next = q_reg + step;
            end
            case (phase_reg)
                PH_FIRST_SYMBOL:
                begin
                    if (chk_ok)
                    begin
                        phase_next = PH_FIRST_COARSE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                PH_FIRST_COARSE:
                begin
                    phase_next = chk_ok ? PH_FINE : PH_SYMBOL;
                end
                PH_FINE:
                begin
                    if (!chk_ok)
                    begin
                        phase_next = PH_COARSE;
                    end
                end
                PH_COARSE:
                begin
                    if (!chk_ok)
                    begin
                        phase_next = PH_SYMBOL;
                    end
                end
                PH_SYMBOL:
                begin
                    if (!chk_ok)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                default:
                begin
                    state_next = ST_FINISH;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FIRST_SYMBOL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        t1_reg         <= t1_next;
        t2_reg         <= t2_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        oor_reg        <= oor_next;
        hold_text_reg  <= hold_text_next;
        hold_print_reg <= hold_print_next;
        out_len_reg    <= out_len_next;
        out_oor_reg    <= out_oor_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign extension_length = out_len_reg;
    assign out_of_range     = out_oor_reg;

    // Walk and result checks.
    `TLFP_ASSERT_IMPL(a_start_when_idle, cmd.start, state_reg == ST_IDLE, "query started while busy")
    `TLFP_ASSERT_IMPL(a_walk_lockstep, state_reg != ST_IDLE, (p_reg - WALK_W'(i_reg)) == (q_reg - WALK_W'(j_reg)), "walk positions diverged")
    `TLFP_ASSERT_IMPL(a_walk_forward, state_reg != ST_IDLE, p_reg >= WALK_W'(i_reg), "walk moved below start")
    `TLFP_ASSERT_IMPL(a_oor_zero_len, out_valid_reg && out_oor_reg, out_len_reg == '0, "out of range item has a length")
    `TLFP_ASSERT_NEXT(a_finish_delivers, (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall), out_valid_reg && (state_reg == ST_IDLE), "finished query not delivered")

endmodule

`default_nettype wire

// File: hw/rtl/two_level_fingerprint_lce_core.sv
// Longest common extension over a stored text with two levels of rank fingerprints.
// In: valid/stall channel of operation, position, other_position, symbol,
// suffix_rank and prefix_with_previous. Out: valid/stall channel of
// extension_length and out_of_range, one item per query, none for loads.
// Configuration: cfg_write, cfg_index, cfg_data (string_length, short_step,
// long_step), to be written while the block is idle; not enforced by the block.
// Symbol and suffix loads are taken back to back while no query is in progress.
// A query holds the input (in_stall high) until its result sits in the
// output register. A query out of range or with equal positions goes
// straight to the result; otherwise each compared position pair passes
// the single read port of the memory in use in steps (address p,
// address q, compare), and a pair at or past the text end is settled
// at the address p step without a compare.
// The output register frees the input side: a new item is accepted while a
// result waits on out_stall; a stalled result holds its value.
// Reset restores the configuration defaults and clears the run heads; the
// text and fingerprint memories are not cleared and need no clearing pass.
// Depends on tlfp_pkg, tlfp_ram, tlfp_print_builder and tlfp_query_engine.
`default_nettype none

module two_level_fingerprint_lce_core
    import tlfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_W-1:0]       cfg_index,
    input  wire logic [LEN_W-1:0]       cfg_data,
    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic [1:0]             operation,
    input  wire logic [LEN_W-1:0]       position,
    input  wire logic [LEN_W-1:0]       other_position,
    input  wire logic [SYMBOL_BITS-1:0] symbol,
    input  wire logic [RANK_W-1:0]      suffix_rank,
    input  wire logic [LEN_W-1:0]       prefix_with_previous,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic [LEN_W-1:0]       extension_length,
    output      logic                   out_of_range
);

    logic [LEN_W-1:0]       string_length_reg;
    logic [LEN_W-1:0]       short_step_reg;
    logic [LEN_W-1:0]       long_step_reg;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       t1;
    logic [LEN_W-1:0]       t2;
    logic                   accept;
    logic                   busy;
    logic                   text_we;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SYMBOL_BITS-1:0] text_rdata;
    logic [PRINT_W-1:0]     print_rdata;
    print_wr_t              print_wr;
    qry_cmd_t               cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_length_reg <= '0;
            short_step_reg    <= LEN_W'(1);
            long_step_reg     <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STRING_LENGTH: string_length_reg <= cfg_data;
                CFG_SHORT_STEP:    short_step_reg    <= cfg_data;
                CFG_LONG_STEP:     long_step_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Effective length and steps.
    always_comb
    begin
        eff_len = (string_length_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                        : string_length_reg;
        t1      = (short_step_reg == '0) ? LEN_W'(1) : short_step_reg;
        t2      = (long_step_reg < t1) ? t1 : long_step_reg;
    end

    // Input handshake and item decode.
    assign in_stall = busy;
    assign accept   = in_valid && !in_stall;
    assign text_we  = accept && (operation == OP_LOAD_SYMBOL)
                      && (position < LEN_W'(MAX_LEN));

    always_comb
    begin
        cmd.start = accept && (operation == OP_QUERY);
        cmd.i     = position;
        cmd.j     = other_position;
        cmd.n     = eff_len;
        cmd.t1    = t1;
        cmd.t2    = t2;
    end

    // Text symbols.
    tlfp_ram #(
        .WIDTH (SYMBOL_BITS),
        .DEPTH (MAX_LEN)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (position[ADDR_W-1:0]),
        .wdata (symbol),
        .raddr (rd_addr),
        .rdata (text_rdata)
    );

    // Fingerprint table writes.
    tlfp_print_builder u_print_builder (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && (operation == OP_LOAD_SUFFIX)),
        .position (position),
        .rank     (suffix_rank),
        .lcp      (prefix_with_previous),
        .t1       (t1),
        .t2       (t2),
        .wr       (print_wr)
    );

    // Coarse and fine fingerprints side by side.
    tlfp_ram #(
        .WIDTH (PRINT_W),
        .DEPTH (MAX_LEN)
    ) u_print_ram (
        .clk   (clk),
        .we    (print_wr.we),
        .waddr (print_wr.addr),
        .wdata ({print_wr.coarse, print_wr.fine}),
        .raddr (rd_addr),
        .rdata (print_rdata)
    );

    // Query walk and result register.
    tlfp_query_engine u_query_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .busy             (busy),
        .rd_addr          (rd_addr),
        .text_rdata       (text_rdata),
        .print_rdata      (print_rdata),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .extension_length (extension_length),
        .out_of_range     (out_of_range)
    );

endmodule

`default_nettype wire
